### rtl/core/assert_macros.svh
// Assertion macros used by the controller RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, skipped while reset is high.
`define VSLW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vslw assertion failed");

// Condition that must never be true on a clock edge outside reset.
`define VSLW_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("vslw forbidden condition seen");

`endif

### rtl/core/vslw_pkg.sv
// Package: widths and controller/datapath signal groups of the line walk.
`default_nettype none

package vslw_pkg;

  localparam int FIELD_W = 16;  // coordinate field width on the ports
  localparam int OFS_W   = 8;   // offset field width
  localparam int MAG_W   = 8;   // |offset|, 0..128
  localparam int SUM_W   = 9;   // path length, 0..384
  localparam int ERR_W   = 12;  // signed axis error, bounded by about 2*N

  typedef struct packed {
    logic load;     // capture a new item
    logic mark_tl;  // present the too-long result
    logic advance;  // take one step
  } vslw_cmd_t;

  typedef struct packed {
    logic zero;      // path length is zero
    logic too_long;  // path length above MAX_STEPS
    logic done;      // shown beat is the final one of this item
  } vslw_stat_t;

endpackage

`default_nettype wire

### rtl/core/vslw_in_if.sv
// Input channel: start voxel and offset with valid/ready.
`default_nettype none

interface vslw_in_if import vslw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] start_x;
  logic signed [FIELD_W-1:0] start_y;
  logic signed [FIELD_W-1:0] start_z;
  logic signed [OFS_W-1:0]   offset_x;
  logic signed [OFS_W-1:0]   offset_y;
  logic signed [OFS_W-1:0]   offset_z;

  modport source (output valid, start_x, start_y, start_z,
                  offset_x, offset_y, offset_z, input ready);
  modport sink   (input valid, start_x, start_y, start_z,
                  offset_x, offset_y, offset_z, output ready);
endinterface

`default_nettype wire

### rtl/core/vslw_out_if.sv
// Output channel: one path voxel per beat with valid/ready.
`default_nettype none

interface vslw_out_if import vslw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] pos_z;
  logic                      last_step;
  logic                      too_long;

  modport source (output valid, pos_x, pos_y, pos_z, last_step, too_long,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_step, too_long,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/vslw_datapath.sv
// Datapath: position, axis error and step count registers of the walk.
`default_nettype none

module vslw_datapath import vslw_pkg::*; #(
  parameter int MAX_STEPS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vslw_cmd_t                 cmd,
  output vslw_stat_t                stat,
  input  logic signed [FIELD_W-1:0] start_x,
  input  logic signed [FIELD_W-1:0] start_y,
  input  logic signed [FIELD_W-1:0] start_z,
  input  logic signed [OFS_W-1:0]   offset_x,
  input  logic signed [OFS_W-1:0]   offset_y,
  input  logic signed [OFS_W-1:0]   offset_z,
  output logic [FIELD_W-1:0]        pos_x,
  output logic [FIELD_W-1:0]        pos_y,
  output logic [FIELD_W-1:0]        pos_z,
  output logic                      last_step,
  output logic                      too_long
);

  // Bits above the port width never reach the output, so keep at most 16.
  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int LIM_W = SUM_W + 2;
  localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_STEPS);

  function automatic logic [MAG_W-1:0] abs_ofs(input logic [OFS_W-1:0] v);
    abs_ofs = v[OFS_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
  endfunction

  logic [CW-1:0]           px, py, pz;
  logic                    nx, ny, nz;
  logic [MAG_W-1:0]        mx, my, mz;
  logic signed [ERR_W-1:0] ex, ey, ez;
  logic [SUM_W-1:0]        total;
  logic [SUM_W-1:0]        rem;
  logic                    tl;

  logic [MAG_W-1:0]        in_mx, in_my, in_mz;
  logic [SUM_W-1:0]        in_total;
  logic                    pick_x, pick_y, pick_z;
  logic signed [ERR_W-1:0] tot_s;

  assign in_mx    = abs_ofs(offset_x);
  assign in_my    = abs_ofs(offset_y);
  assign in_mz    = abs_ofs(offset_z);
  assign in_total = SUM_W'(in_mx) + SUM_W'(in_my) + SUM_W'(in_mz);

  // Largest error moves; ties go x, then y, then z.
  assign pick_x = (ex >= ey) && (ex >= ez);
  assign pick_y = !pick_x && (ey >= ez);
  assign pick_z = !pick_x && !pick_y;
  assign tot_s  = $signed(ERR_W'(total));

  always_ff @(posedge clk) begin
    if (rst) begin
      tl <= 1'b0;
    end else if (cmd.load) begin
      tl <= 1'b0;
    end else if (cmd.mark_tl) begin
      tl <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px    <= CW'(start_x);
      py    <= CW'(start_y);
      pz    <= CW'(start_z);
      nx    <= offset_x[OFS_W-1];
      ny    <= offset_y[OFS_W-1];
      nz    <= offset_z[OFS_W-1];
      mx    <= in_mx;
      my    <= in_my;
      mz    <= in_mz;
      // error for the first step is just |d|
      ex    <= $signed(ERR_W'(in_mx));
      ey    <= $signed(ERR_W'(in_my));
      ez    <= $signed(ERR_W'(in_mz));
      total <= in_total;
      rem   <= in_total;
    end else if (cmd.advance) begin
      ex  <= ex + $signed(ERR_W'(mx)) - (pick_x ? tot_s : '0);
      ey  <= ey + $signed(ERR_W'(my)) - (pick_y ? tot_s : '0);
      ez  <= ez + $signed(ERR_W'(mz)) - (pick_z ? tot_s : '0);
      if (pick_x) px <= px + (nx ? {CW{1'b1}} : CW'(1));
      if (pick_y) py <= py + (ny ? {CW{1'b1}} : CW'(1));
      if (pick_z) pz <= pz + (nz ? {CW{1'b1}} : CW'(1));
      rem <= rem - 1'b1;
    end
  end

  assign stat.zero     = (total == '0);
  assign stat.too_long = (LIM_W'(total) > MAX_L);
  assign stat.done     = tl || (rem == '0);

  assign pos_x     = FIELD_W'(px);
  assign pos_y     = FIELD_W'(py);
  assign pos_z     = FIELD_W'(pz);
  assign last_step = !tl && (rem == '0);
  assign too_long  = tl;

endmodule

`default_nettype wire

### rtl/core/vslw_ctrl.sv
// Controller: sequences load, length check and step beats of one item.
`default_nettype none

`include "assert_macros.svh"

module vslw_ctrl import vslw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  vslw_stat_t stat,
  output vslw_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t state;

  logic in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.load = in_fire;
      ST_CHECK: begin
        if (!stat.zero) begin
          cmd.mark_tl = stat.too_long;
          cmd.advance = !stat.too_long;
        end
      end
      ST_EMIT:  cmd.advance = out_fire && !stat.done;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state    <= ST_CHECK;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (stat.zero) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end else begin
            state     <= ST_EMIT;
            out_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_fire && stat.done) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  `VSLW_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `VSLW_ASSERT(a_accept_closes, clk, rst, in_fire |=> (!in_ready && !out_valid))
  `VSLW_ASSERT(a_final_reopens, clk, rst, (out_fire && stat.done) |=> in_ready)
  `VSLW_ASSERT(a_step_holds, clk, rst, (out_fire && !stat.done) |=> out_valid)

endmodule

`default_nettype wire

### rtl/core/voxel_six_connected_line_walk.sv
// Sequence: accept beat, length check, then one result beat per cycle while the
//   output is ready; an item gives N beats (N = |dx|+|dy|+|dz|), a zero offset
//   none and a too-long path one; the step counter sets this.
// Output backpressure holds each stalled beat; no new item is taken before the final beat.
// Reset (rst, synchronous, active high) returns to idle with ready low; ready
//   rises in the cycle after reset is released.
`default_nettype none

module voxel_six_connected_line_walk import vslw_pkg::*; #(
  parameter int MAX_STEPS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  vslw_in_if.sink    items,
  vslw_out_if.source results
);

  vslw_cmd_t  cmd;
  vslw_stat_t stat;

  // Controller: idle -> check length -> emit beats until the final one (a zero offset returns to idle).
  vslw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: the position registers double as the output register, so a
  // beat stays stable until taken and the next step is computed on accept.
  vslw_datapath #(
    .MAX_STEPS  (MAX_STEPS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .start_x   (items.start_x),
    .start_y   (items.start_y),
    .start_z   (items.start_z),
    .offset_x  (items.offset_x),
    .offset_y  (items.offset_y),
    .offset_z  (items.offset_z),
    .pos_x     (results.pos_x),
    .pos_y     (results.pos_y),
    .pos_z     (results.pos_z),
    .last_step (results.last_step),
    .too_long  (results.too_long)
  );

endmodule

`default_nettype wire
